>>> src/mpf_pkg.sv
// Package for the multichannel PWM fader: sizes, reset values, action codes
// and the item and control structs shared by the timer, channel bank and top.
// No dependencies.
package mpf_pkg;

    localparam int CHANNELS = 16;
    localparam int LAMP_CH = (CHANNELS < 16) ? CHANNELS : 16;

    localparam logic [7:0] RESET_PERIOD_TOP   = 8'd17;
    localparam logic [7:0] RESET_PERIODS_LEFT = 8'd32;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_ARM   = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] channel;
        logic [7:0] value;
    } item_t;

    // Control from the timer to the channel bank for the item being executed.
    typedef struct packed {
        logic tick;
        logic period_end;
        logic load;
        logic write;
    } ctl_t;

endpackage

>>> src/mpf_timer.sv
// Phase counter, period countdown and pending count of the PWM fader.
// Decodes the held item into control for the channel bank. Uses mpf_pkg.
module mpf_timer
    import mpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  item_t      item,
    input  logic [7:0] period_top,
    output ctl_t       ctl,
    output logic       pending_free_next,
    output logic [7:0] phase
);

    logic [7:0] phase_reg, phase_next;
    logic [7:0] periods_left_reg, periods_left_next;
    logic [7:0] pending_count_reg, pending_count_next;
    logic [7:0] phase_inc;
    logic [7:0] left_dec;

    assign phase_inc = phase_reg + 8'd1;
    assign left_dec  = periods_left_reg - 8'd1;

    always_comb begin
        ctl.tick       = (item.action == ACT_TICK);
        ctl.write      = (item.action == ACT_WRITE);
        ctl.period_end = ctl.tick && (phase_inc == period_top);
        ctl.load       = ctl.period_end && (left_dec == 8'd0);

        phase_next         = phase_reg;
        periods_left_next  = periods_left_reg;
        pending_count_next = pending_count_reg;
        if (ctl.tick) begin
            phase_next = ctl.period_end ? 8'd0 : phase_inc;
        end
        if (ctl.period_end) begin
            periods_left_next = ctl.load ? pending_count_reg : left_dec;
        end
        if (ctl.load) begin
            pending_count_next = 8'd0;
        end else if (item.action == ACT_ARM) begin
            pending_count_next = item.value;
        end
    end

    assign pending_free_next = (pending_count_next == 8'd0);
    assign phase             = phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= 8'd0;
            periods_left_reg  <= RESET_PERIODS_LEFT;
            pending_count_reg <= 8'd0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            periods_left_reg  <= periods_left_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

>>> src/mpf_bank.sv
// Per-channel level, delta and pending delta registers with the PWM compare.
// Uses mpf_pkg; driven by the control struct from mpf_timer.
module mpf_bank
    import mpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  ctl_t        ctl,
    input  item_t       item,
    input  logic [7:0]  phase,
    output logic [15:0] lamp_next
);

    logic [7:0] level_reg [CHANNELS];
    logic [7:0] delta_reg [CHANNELS];
    logic [7:0] pend_reg  [CHANNELS];

    // Drive a lamp on while the phase is below its level.
    always_comb begin
        lamp_next = 16'd0;
        for (int i = 0; i < LAMP_CH; i++) begin
            lamp_next[i] = (phase < level_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                level_reg[i] <= 8'd0;
                delta_reg[i] <= 8'd0;
                pend_reg[i]  <= 8'd0;
            end
        end else if (advance) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (ctl.period_end) begin
                    level_reg[i] <= level_reg[i] + delta_reg[i];
                end
                if (ctl.load) begin
                    delta_reg[i] <= pend_reg[i];
                end
                if (ctl.write && (32'(item.channel) == i)) begin
                    pend_reg[i] <= item.value;
                end
            end
        end
    end

endmodule

>>> src/multichannel_pwm_fader_top.sv
// Top level of the multichannel PWM fader: input register, result register,
// period_top configuration register. Depends on mpf_pkg, mpf_timer, mpf_bank.
//
// Usage:
//   Input channel (s_valid/s_ready): one transaction per item. action selects
//   a PWM tick, a write of one channel's pending delta, or an arm of the
//   pending period count. Every item yields exactly one result transaction.
//   Result channel (m_valid/m_ready): m_lamp_bits carries the lamp pattern
//   (held between ticks), m_pending_free says the pending count is zero and
//   m_period_end marks a tick that closed a PWM period and stepped the fade.
//   Config channel (cfg_valid/cfg_ready): writes period_top; always ready.
//   Write it only while no item is in flight.
// Timing: an accepted item is held in the input register and executes into
//   the result register once that register is free or draining; m_valid
//   then rises. One item per cycle is sustained while m_ready stays high;
//   the state update of the channel bank and timer as each item executes
//   sets that figure.
// Reset (aresetn low, synchronous): levels, deltas and pending deltas clear,
//   phase and pending count go to zero, the countdown to 32, period_top to 17
//   and both pipeline registers empty.
// Stall: while m_ready is low the result register holds; the input register
//   still takes one item, after which s_ready drops until the result drains.
module multichannel_pwm_fader_top
    import mpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_channel,
    input  logic [7:0]  s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_lamp_bits,
    output logic        m_pending_free,
    output logic        m_period_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_period_top
);

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [15:0] lamp_reg;
    logic        pending_free_reg;
    logic        period_end_reg;
    logic [7:0]  period_top_reg;

    logic        advance;
    ctl_t        ctl;
    logic        pending_free_next;
    logic [15:0] lamp_next;
    logic [7:0]  phase;

    // Execute the held item when the result register is free or draining.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_top_reg <= RESET_PERIOD_TOP;
        end else if (cfg_valid) begin
            period_top_reg <= cfg_period_top;
        end
    end

    // Input register: capture a new transaction, drop valid once executed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.action  <= s_action;
            in_item_reg.channel <= s_channel;
            in_item_reg.value   <= s_value;
        end
    end

    mpf_timer u_timer (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .advance           (advance),
        .item              (in_item_reg),
        .period_top        (period_top_reg),
        .ctl               (ctl),
        .pending_free_next (pending_free_next),
        .phase             (phase)
    );

    mpf_bank u_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .ctl       (ctl),
        .item      (in_item_reg),
        .phase     (phase),
        .lamp_next (lamp_next)
    );

    // Result register; the lamp field doubles as the held lamp state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            lamp_reg         <= 16'd0;
            pending_free_reg <= 1'b1;
            period_end_reg   <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg    <= 1'b1;
                pending_free_reg <= pending_free_next;
                period_end_reg   <= ctl.period_end;
                if (ctl.tick) begin
                    lamp_reg <= lamp_next;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_lamp_bits    = lamp_reg;
    assign m_pending_free = pending_free_reg;
    assign m_period_end   = period_end_reg;

endmodule

>>> verif/tb_top.sv
// Testbench for multichannel_pwm_fader_top: directed and random tick, delta-write and
// arm transactions, checked field by field against an in-bench fade/PWM predictor.
// Depends on mpf_pkg and the RTL of multichannel_pwm_fader_top.
module tb_top;
    import mpf_pkg::*;

    // Action code that the block ignores; the package only names the three real ones.
    localparam logic [1:0] ACT_IGNORED    = 2'd3;
    // Cycles without any handshake before the run is declared hung.
    localparam int         WATCHDOG_LIMIT = 2000;
    // Extra cycles to let the two-stage pipeline empty before a config write.
    localparam int         SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [15:0] lamp_bits;
        logic        pending_free;
        logic        period_end;
    } lamp_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action       = ACT_TICK;
    logic [3:0]  s_channel      = '0;
    logic [7:0]  s_value        = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [15:0] m_lamp_bits;
    logic        m_pending_free;
    logic        m_period_end;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_period_top = '0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    multichannel_pwm_fader_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_channel      (s_channel),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lamp_bits    (m_lamp_bits),
        .m_pending_free (m_pending_free),
        .m_period_end   (m_period_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_period_top (cfg_period_top)
    );

    // ------------------------------------------------------------------
    // Fader predictor state: mirrors the block's registers.
    // ------------------------------------------------------------------
    logic [7:0]  fade_period_top;
    logic [7:0]  fade_level      [CHANNELS];
    logic [7:0]  fade_delta      [CHANNELS];
    logic [7:0]  fade_next_delta [CHANNELS];
    logic [7:0]  fade_countdown;
    logic [7:0]  fade_next_count;
    logic [7:0]  fade_phase;
    logic [15:0] fade_lamps;

    lamp_result_t expected_lamps_q[$];

    // Run bookkeeping.
    int items_sent;
    int results_checked;
    int mismatch_count;
    int period_ends_seen;
    int fade_loads_seen;
    int period_top_writes;

    // Idling controls, flipped per test to get stretches with and without gaps.
    bit tx_gap_on;
    bit rx_stall_on;
    int rx_stall_left;

    function automatic void reset_fader_model();
        fade_period_top = RESET_PERIOD_TOP;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            fade_level[ch]      = '0;
            fade_delta[ch]      = '0;
            fade_next_delta[ch] = '0;
        end
        fade_countdown  = RESET_PERIODS_LEFT;
        fade_next_count = '0;
        fade_phase      = '0;
        fade_lamps      = '0;
    endfunction

    // Advance the fader by one transaction and return the result it must produce.
    function automatic lamp_result_t predict_lamps(item_t it);
        lamp_result_t res;
        logic         ended;
        ended = 1'b0;
        case (it.action)
            ACT_TICK: begin
                // Compare against the phase before it advances.
                fade_lamps = '0;
                for (int ch = 0; ch < LAMP_CH; ch++) begin
                    if (fade_phase < fade_level[ch]) fade_lamps[ch] = 1'b1;
                end
                fade_phase = fade_phase + 8'd1;
                // Period ends only on an exact hit, so a phase past the top wraps first.
                if (fade_phase == fade_period_top) begin
                    ended      = 1'b1;
                    fade_phase = '0;
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        fade_level[ch] = fade_level[ch] + fade_delta[ch];
                    end
                    fade_countdown = fade_countdown - 8'd1;
                    // Load the pending set; a zero count makes the countdown wrap to 255.
                    if (fade_countdown == 8'd0) begin
                        for (int ch = 0; ch < CHANNELS; ch++) begin
                            fade_delta[ch] = fade_next_delta[ch];
                        end
                        fade_countdown  = fade_next_count;
                        fade_next_count = '0;
                        fade_loads_seen++;
                    end
                    period_ends_seen++;
                end
            end
            ACT_WRITE: begin
                if (int'(it.channel) < CHANNELS) fade_next_delta[it.channel] = it.value;
            end
            ACT_ARM: begin
                fade_next_count = it.value;
            end
            default: begin
                // Ignored action: state holds, result repeats the lamp register.
            end
        endcase
        res.lamp_bits    = fade_lamps;
        res.pending_free = (fade_next_count == 8'd0);
        res.period_end   = ended;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: check the result side first, then record config and
    // input transactions of the same edge. All samples are pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : lamp_monitor
        lamp_result_t want;
        item_t        it;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_lamps_q.size() == 0) begin
                    $error("unexpected result transaction: lamp_bits %h free %b end %b",
                           m_lamp_bits, m_pending_free, m_period_end);
                    mismatch_count++;
                end else begin
                    want = expected_lamps_q.pop_front();
                    if (m_lamp_bits !== want.lamp_bits) begin
                        $error("lamp_bits: expected %h, got %h", want.lamp_bits, m_lamp_bits);
                        mismatch_count++;
                    end
                    if (m_pending_free !== want.pending_free) begin
                        $error("pending_free: expected %b, got %b",
                               want.pending_free, m_pending_free);
                        mismatch_count++;
                    end
                    if (m_period_end !== want.period_end) begin
                        $error("period_end: expected %b, got %b",
                               want.period_end, m_period_end);
                        mismatch_count++;
                    end
                    results_checked++;
                end
            end
            if (cfg_valid && cfg_ready) fade_period_top = cfg_period_top;
            if (s_valid && s_ready) begin
                it.action  = s_action;
                it.channel = s_channel;
                it.value   = s_value;
                expected_lamps_q.push_back(predict_lamps(it));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drop m_ready for random stretches while stalling is enabled.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            rx_stall_left <= 0;
        end else if (!rx_stall_on) begin
            m_ready <= 1'b1;
        end else if (rx_stall_left != 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= pick_gap() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no channel moves a transaction for too long.
    // ------------------------------------------------------------------
    int idle_cycles;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("[multichannel_pwm_fader_top] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: optional gap, then hold valid and payload until accepted.
    // Called and returning at a rising edge; only one update of s_valid per edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] act, input logic [3:0] ch,
                             input logic [7:0] val);
        int gap;
        gap = (tx_gap_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_channel <= ch;
        s_value   <= val;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Hold the sender and wait until every expected result has been checked.
    task automatic settle_results();
        s_valid <= 1'b0;
        while (results_checked != items_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write period_top with the pipeline empty.
    task automatic set_period_top(input logic [7:0] top);
        settle_results();
        cfg_valid      <= 1'b1;
        cfg_period_top <= top;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_top_writes++;
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // Advance ticks until the running period has just ended (phase back at zero).
    task automatic finish_running_period();
        int n;
        settle_results();
        n = int'(8'(fade_period_top - fade_phase));
        if (n == 0) n = 256;
        repeat (n) send_tick();
    endtask

    function automatic logic [7:0] pick_delta();
        int mag;
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        mag = $urandom_range(1, 4);
        return ($urandom_range(0, 1) == 0) ? 8'(mag) : 8'(-mag);
    endfunction

    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 3));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every action, both channel extremes, delta extremes, ignored action, arm values.
    task automatic test_basic_operations();
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        send_item(ACT_TICK, 4'd0, 8'd0);
        send_item(ACT_WRITE, 4'd0, 8'h01);
        send_item(ACT_WRITE, 4'd15, 8'hFF);
        send_item(ACT_WRITE, 4'd7, 8'h80);
        send_item(ACT_WRITE, 4'd8, 8'h7F);
        send_item(ACT_WRITE, 4'd3, 8'h00);
        send_item(ACT_IGNORED, 4'd15, 8'hFF);
        send_item(ACT_IGNORED, 4'd0, 8'h00);
        send_item(ACT_ARM, 4'd15, 8'hFF);
        send_item(ACT_ARM, 4'd0, 8'h00);
        send_item(ACT_ARM, 4'd5, 8'd3);
        repeat (6) send_tick();
    endtask

    // period_top at its low extreme: every tick closes a period. Covers the first
    // load, a zero count loaded, and the 256-period wrap that follows it.
    task automatic test_single_tick_periods();
        finish_running_period();
        set_period_top(8'd1);
        tx_gap_on   = 1'b0;
        rx_stall_on = 1'b0;
        repeat (150) send_tick();
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        repeat (150) send_tick();
    endtask

    // period_top zero: a period is the full 256-tick wrap of the phase.
    task automatic test_period_top_zero();
        set_period_top(8'd0);
        repeat (270) send_tick();
    endtask

    // Lower period_top below the running phase: phase counts on through 255 first.
    task automatic test_phase_beyond_top();
        set_period_top(8'd5);
        repeat (260) send_tick();
    endtask

    // One well-formed fade program: pending deltas, an arm, then a tick run
    // with occasional stray writes, arms and ignored actions mixed in.
    task automatic run_fade_program();
        int r;
        repeat ($urandom_range(0, 4)) begin
            send_item(ACT_WRITE, 4'($urandom_range(0, 15)), pick_delta());
        end
        if ($urandom_range(0, 4) != 0) send_item(ACT_ARM, 4'($urandom_range(0, 15)), pick_count());
        repeat ($urandom_range(4, 40)) begin
            r = $urandom_range(0, 99);
            if (r < 90) begin
                send_tick();
            end else if (r < 95) begin
                send_item(ACT_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end else if (r < 98) begin
                send_item(ACT_IGNORED, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end else begin
                send_item(ACT_ARM, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Six phases, each with its own period_top and a per-phase idling mix; each
    // phase pauses once midway until all results have drained.
    task automatic test_random_programs();
        int         first;
        bit         paused;
        logic [7:0] top;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: top = 8'd3;
                1: top = 8'd1;
                2: top = 8'd255;
                3: top = 8'($urandom_range(2, 24));
                4: top = 8'($urandom_range(0, 255));
                default: top = 8'($urandom_range(2, 12));
            endcase
            set_period_top(top);
            tx_gap_on   = (p != 0) && (p != 3);
            rx_stall_on = (p != 0) && (p != 1);
            first  = items_sent;
            paused = 1'b0;
            while (items_sent - first < 100) begin
                run_fade_program();
                if (!paused && items_sent - first >= 50) begin
                    settle_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_fader_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_operations();
        test_single_tick_periods();
        test_period_top_zero();
        test_phase_beyond_top();
        test_random_programs();

        // Drain and let the pipeline run dry before the verdict.
        settle_results();
        if (expected_lamps_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_lamps_q.size());
            mismatch_count++;
        end

        $display("Run covered %0d transactions: %0d period ends, %0d fade loads,",
                 items_sent, period_ends_seen, fade_loads_seen);
        $display("%0d period_top writes, with sender gaps and receiver stalls.",
                 period_top_writes);
        if (mismatch_count == 0) begin
            $display("[multichannel_pwm_fader_top] OK");
        end else begin
            $display("[multichannel_pwm_fader_top] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/mpf_pkg.sv
src/mpf_timer.sv
src/mpf_bank.sv
src/multichannel_pwm_fader_top.sv
verif/tb_top.sv
